// ===== rtl/gmps_pkg.sv =====
// Package for the grid minimum path sum block.
// Holds sizes, queue geometry, work and result item types, and helper
// functions shared by the front, back and queue modules. No dependencies.
`default_nettype none
package gmps_pkg;

  localparam int MAX_COLUMNS = 1024;
  localparam int MAX_ROWS    = 1024;

  localparam int SIZE_W    = 11;
  localparam int COL_W     = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CELL_W    = 16;
  localparam int COST_W    = 32;
  localparam int CFG_IDX_W = 4;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT    = CFG_IDX_W'(0),
    REG_COLUMN_COUNT = CFG_IDX_W'(1)
  } cfg_reg_t;

  typedef struct packed {
    logic [CELL_W-1:0] weight;
    logic [COL_W-1:0]  col;
    logic              first_row;
    logic              first_col;
    logic              is_final;
  } work_t;

  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic              is_final;
  } result_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] limit);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > limit) begin
      r = limit;
    end
    return r;
  endfunction

  function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                input logic [CELL_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + (COST_W + 1)'(b);
    return s[COST_W] ? COST_MAX : s[COST_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/gmps_workq.sv =====
// Four-entry queue of classified work items between front and back.
// Depends on gmps_pkg (work_t, queue geometry).
`default_nettype none
module gmps_workq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire gmps_pkg::work_t push_data,
  output logic                 full,
  input  wire logic            pop,
  output gmps_pkg::work_t      pop_data,
  output logic                 empty
);
  import gmps_pkg::*;

  work_t             mem [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_CW-1:0]   cnt_r, cnt_nxt;
  logic              wr_en, rd_en;

  assign full     = (cnt_r == Q_CW'(Q_DEPTH));
  assign empty    = (cnt_r == '0);
  assign wr_en    = push && !full;
  assign rd_en    = pop && !empty;
  assign pop_data = mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + Q_CW'(1);
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - Q_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/gmps_outq.sv =====
// Four-entry result queue that drives the output channel.
// Depends on gmps_pkg (result_t, queue geometry).
`default_nettype none
module gmps_outq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire gmps_pkg::result_t push_data,
  output logic                   full,
  input  wire logic              pop,
  output gmps_pkg::result_t      pop_data,
  output logic                   empty
);
  import gmps_pkg::*;

  result_t           mem [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_CW-1:0]   cnt_r, cnt_nxt;
  logic              wr_en, rd_en;

  assign full     = (cnt_r == Q_CW'(Q_DEPTH));
  assign empty    = (cnt_r == '0);
  assign wr_en    = push && !full;
  assign rd_en    = pop && !empty;
  assign pop_data = mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + Q_CW'(1);
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - Q_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/gmps_front.sv =====
// Front end: size registers, row/column tracking, classification of cells.
// Depends on gmps_pkg (work_t, clamp_size, register codes).
`default_nettype none
module gmps_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [gmps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [gmps_pkg::SIZE_W-1:0]    cfg_data,
  input  wire logic                           in_push,
  output logic                                in_full,
  input  wire logic [gmps_pkg::CELL_W-1:0]    in_cell_value,
  output logic                                wq_push,
  output gmps_pkg::work_t                     wq_data,
  input  wire logic                           wq_full
);
  import gmps_pkg::*;

  logic [SIZE_W-1:0] row_cnt_r, col_cnt_r;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic              acc, cfg_wr, cfg_restart, last_col, last_row;
  logic [SIZE_W-1:0] row_p1, col_p1;

  assign cfg_ready   = 1'b1;
  assign cfg_wr      = cfg_valid && cfg_ready;
  assign cfg_restart = cfg_wr && ((cfg_index == REG_ROW_COUNT) ||
                                  (cfg_index == REG_COLUMN_COUNT));
  assign in_full     = wq_full;
  assign acc         = in_push && !wq_full;
  assign wq_push     = acc;

  assign row_p1   = SIZE_W'(row_r) + SIZE_W'(1);
  assign col_p1   = SIZE_W'(col_r) + SIZE_W'(1);
  assign last_col = (col_p1 >= col_cnt_r);
  assign last_row = (row_p1 >= row_cnt_r);

  always_comb begin
    wq_data.weight    = in_cell_value;
    wq_data.col       = col_r;
    wq_data.first_row = (row_r == '0);
    wq_data.first_col = (col_r == '0);
    wq_data.is_final  = (row_p1 == row_cnt_r) && (col_p1 == col_cnt_r);
  end

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (cfg_restart) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (acc) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_p1[ROW_W-1:0];
      end else begin
        col_nxt = col_p1[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= SIZE_W'(1);
      col_cnt_r <= SIZE_W'(1);
      row_r     <= '0;
      col_r     <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
      if (cfg_wr) begin
        unique case (cfg_index)
          REG_ROW_COUNT: begin
            row_cnt_r <= clamp_size(cfg_data, SIZE_W'(MAX_ROWS));
          end
          REG_COLUMN_COUNT: begin
            col_cnt_r <= clamp_size(cfg_data, SIZE_W'(MAX_COLUMNS));
          end
          default: begin
          end
        endcase
      end
    end
  end

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    SIZE_W'(col_r) < col_cnt_r) else $error("column index beyond column count");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    SIZE_W'(row_r) < row_cnt_r) else $error("row index beyond row count");

  a_final_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && wq_data.is_final && !cfg_wr) |=> (row_r == '0 && col_r == '0))
    else $error("grid did not restart after final cell");

endmodule
`default_nettype wire

// ===== rtl/gmps_back.sv =====
// Back end: line buffer of best costs, left cost, min and saturating add.
// Depends on gmps_pkg (work_t, result_t, sat_add).
`default_nettype none
module gmps_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wq_empty,
  input  wire gmps_pkg::work_t      wq_data,
  output logic                      wq_pop,
  output logic                      oq_push,
  output gmps_pkg::result_t         oq_data,
  input  wire logic                 oq_full
);
  import gmps_pkg::*;

  logic [COST_W-1:0] line_mem [MAX_COLUMNS];
  logic [COST_W-1:0] mem_rd_r, fwd_data_r, left_r, above, base, cost;
  work_t             work_r;
  logic              s_vld_r, fwd_r, done, take, hazard;

  assign done    = s_vld_r && !oq_full;
  assign take    = !wq_empty && (!s_vld_r || done);
  assign wq_pop  = take;
  assign hazard  = done && (work_r.col == wq_data.col);
  assign above   = fwd_r ? fwd_data_r : mem_rd_r;

  always_comb begin
    priority if (work_r.first_row && work_r.first_col) begin
      base = '0;
    end else if (work_r.first_row) begin
      base = left_r;
    end else if (work_r.first_col) begin
      base = above;
    end else begin
      base = (above < left_r) ? above : left_r;
    end
    cost = sat_add(base, work_r.weight);
  end

  assign oq_push          = done;
  assign oq_data.cost     = cost;
  assign oq_data.is_final = work_r.is_final;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
      left_r  <= '0;
    end else begin
      if (take) begin
        s_vld_r <= 1'b1;
      end else if (done) begin
        s_vld_r <= 1'b0;
      end
      if (done) begin
        left_r <= cost;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      work_r     <= wq_data;
      fwd_r      <= hazard;
      fwd_data_r <= cost;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      line_mem[work_r.col] <= cost;
    end
    if (take) begin
      mem_rd_r <= line_mem[wq_data.col];
    end
  end

  a_pop_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (s_vld_r && oq_full) |-> !wq_pop) else $error("stage overwritten while stalled");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s_vld_r && oq_full) |=> (s_vld_r && $stable(work_r)))
    else $error("stalled item lost");

  a_fwd_same_col: assert property (@(posedge clk) disable iff (!rst_n)
    take && hazard |=> fwd_r) else $error("missed write-to-read forward");

endmodule
`default_nettype wire

// ===== rtl/grid_min_path_sum.sv =====
// Grid minimum path sum: streams grid cells row-major, returns per-cell best cost.
// Path: an accepted cell goes through the work queue and the back-end stage into the output queue.
// Throughput: one cell per cycle while the output queue has room; a full output queue stalls the back end.
// Reset: synchronous, active low; sizes go to 1x1 and the grid restarts.
// The line buffer has no clearing pass; each grid writes its top row first.
// Depends on gmps_pkg, gmps_front, gmps_workq, gmps_back, gmps_outq.
`default_nettype none
module grid_min_path_sum (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [gmps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [gmps_pkg::SIZE_W-1:0]    cfg_data,
  input  wire logic                           in_push,
  output logic                                in_full,
  input  wire logic [gmps_pkg::CELL_W-1:0]    in_cell_value,
  output logic                                out_empty,
  input  wire logic                           out_pop,
  output logic [gmps_pkg::COST_W-1:0]         out_path_cost,
  output logic                                out_is_final
);
  import gmps_pkg::*;

  work_t   wq_in, wq_out;
  result_t oq_in, oq_out;
  logic    wq_push, wq_full, wq_pop, wq_empty;
  logic    oq_push, oq_full;

  gmps_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_cell_value (in_cell_value),
    .wq_push       (wq_push),
    .wq_data       (wq_in),
    .wq_full       (wq_full)
  );

  gmps_workq u_workq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (wq_push),
    .push_data (wq_in),
    .full      (wq_full),
    .pop       (wq_pop),
    .pop_data  (wq_out),
    .empty     (wq_empty)
  );

  gmps_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .wq_empty (wq_empty),
    .wq_data  (wq_out),
    .wq_pop   (wq_pop),
    .oq_push  (oq_push),
    .oq_data  (oq_in),
    .oq_full  (oq_full)
  );

  gmps_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (oq_push),
    .push_data (oq_in),
    .full      (oq_full),
    .pop       (out_pop),
    .pop_data  (oq_out),
    .empty     (out_empty)
  );

  assign out_path_cost = oq_out.cost;
  assign out_is_final  = oq_out.is_final;

endmodule
`default_nettype wire
